// ===== hw/rtl/cqrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: shared package
// Request and result payload types, command and status codes, and the
// widths that the interface fixes.
// ----------------------------------------------------------------------------
package cqrp_pkg;

	localparam int unsigned DEPTH_DEFAULT     = 16;
	localparam int unsigned WORD_BITS_DEFAULT = 32;

	// Interface field widths.
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned PAIR_W  = CNT_W - 1;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ = 2'd0,
		KIND_DEQ = 2'd1,
		KIND_REV = 2'd2
	} cqrp_kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_INVALID = 2'd3
	} cqrp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_REV_WA,
		ST_REV_WB
	} cqrp_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		logic [CNT_W-1:0]          reverse_count;
	} cqrp_cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [STAT_W-1:0]         status;
		logic [CNT_W-1:0]          occupancy;
	} cqrp_res_t;

endpackage

// ===== hw/rtl/circular_queue_reverse_prefix.sv =====
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse
// A circular FIFO of words that wraps at a programmable capacity. Enqueue,
// dequeue, and in-place reversal of the oldest k entries by pairwise swaps
// through a two-read, one-write slot memory under a small sequencer.
// ----------------------------------------------------------------------------
// Enqueue and rejected requests give their result in the cycle after
// acceptance; a dequeue passes a registered memory read and state ST_DEQ; a
// reverse of k entries passes ST_REV_WA and ST_REV_WB for each of floor(k/2)
// swapped pairs, as the single write port writes each slot in its own state.
// busy is high while a dequeue or reverse is in progress. Results are shown
// for one cycle with done; the receiver cannot stall them.
// Reset empties the queue and sets the capacity to 16; slot contents are not
// cleared, and only written slots ever reach a result.
module circular_queue_reverse_prefix #(
	parameter int unsigned DEPTH     = cqrp_pkg::DEPTH_DEFAULT,
	parameter int unsigned WORD_BITS = cqrp_pkg::WORD_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  cqrp_pkg::cqrp_cmd_t             cmd,
	output logic                            done,
	output cqrp_pkg::cqrp_res_t             result,
	input  logic                            cfg_we,
	input  logic [cqrp_pkg::CNT_W-1:0]      cfg_wdata
);

	localparam int unsigned CNT_W  = cqrp_pkg::CNT_W;
	localparam int unsigned PAIR_W = cqrp_pkg::PAIR_W;
	localparam int unsigned IDX_W  = $clog2(DEPTH);
	localparam int unsigned AW     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

	cqrp_pkg::cqrp_state_t state_q, state_d;

	logic [WORD_BITS-1:0] slots_q [DEPTH];
	logic [WORD_BITS-1:0] rd_a_q, rd_b_q;

	logic [CNT_W-1:0]  cap_q;
	logic [IDX_W-1:0]  head_q, tail_q, a_q, b_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAIR_W-1:0] pairs_q;
	logic              done_q;
	cqrp_pkg::cqrp_res_t result_q;

	logic [CNT_W-1:0]  cap_eff;
	logic              accept;
	logic              rev_ok;
	logic [PAIR_W-1:0] rev_pairs;
	logic [IDX_W-1:0]  rev_last;

	logic [IDX_W-1:0]  head_d, tail_d, a_d, b_d;
	logic [CNT_W-1:0]  count_d;
	logic [PAIR_W-1:0] pairs_d;
	logic              res_valid;
	cqrp_pkg::cqrp_res_t res_d;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr, raddr_a, raddr_b;
	logic [WORD_BITS-1:0] mem_wdata;

	logic [WORD_BITS-1:0]          store_word;
	logic [cqrp_pkg::VALUE_W-1:0]  deq_word;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [AW-1:0] s;
		s = AW'(idx) + AW'(1);
		return (s >= AW'(cap)) ? '0 : IDX_W'(s);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [AW-1:0] s;
		s = (idx == '0) ? AW'(cap) : AW'(idx);
		return IDX_W'(s - AW'(1));
	endfunction

	// The stored word is the low WORD_BITS of the value; dequeued words are
	// sign-extended when narrower than the output field.
	generate
		if (WORD_BITS >= cqrp_pkg::VALUE_W) begin : g_wide
			assign store_word = WORD_BITS'($unsigned(cmd.value));
			assign deq_word   = cqrp_pkg::VALUE_W'(rd_a_q);
		end else begin : g_narrow
			assign store_word = cmd.value[WORD_BITS-1:0];
			assign deq_word   = cqrp_pkg::VALUE_W'($signed(rd_a_q));
		end
	endgenerate

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign busy      = (state_q != cqrp_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign rev_ok    = (cmd.reverse_count != '0) && (cmd.reverse_count <= count_q);
	assign rev_pairs = PAIR_W'(cmd.reverse_count >> 1);

	// Slot of the k-th oldest entry; the sum stays below twice the capacity.
	always_comb begin
		logic [AW-1:0] s;
		s = AW'(head_q) + AW'(cmd.reverse_count) - AW'(1);
		if (s >= AW'(cap_eff)) begin
			s = s - AW'(cap_eff);
		end
		rev_last = IDX_W'(s);
	end

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cqrp_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.kind == cqrp_pkg::KIND_DEQ && count_q != '0) begin
						state_d = cqrp_pkg::ST_DEQ;
					end else if (cmd.kind == cqrp_pkg::KIND_REV && rev_ok
							&& rev_pairs != '0) begin
						state_d = cqrp_pkg::ST_REV_WA;
					end
				end
			end
			cqrp_pkg::ST_DEQ:    state_d = cqrp_pkg::ST_IDLE;
			cqrp_pkg::ST_REV_WA: state_d = cqrp_pkg::ST_REV_WB;
			cqrp_pkg::ST_REV_WB: begin
				state_d = (pairs_q == PAIR_W'(1)) ? cqrp_pkg::ST_IDLE
				                                   : cqrp_pkg::ST_REV_WA;
			end
			default: state_d = cqrp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: datapath controls and results.
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		a_d       = a_q;
		b_d       = b_q;
		pairs_d   = pairs_q;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = store_word;
		raddr_a   = head_q;
		raddr_b   = rev_last;
		res_valid = 1'b0;
		res_d.read_value = '0;
		res_d.status     = cqrp_pkg::STAT_OK;
		res_d.occupancy  = count_q;
		unique case (state_q)
			cqrp_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						cqrp_pkg::KIND_ENQ: begin
							res_valid = 1'b1;
							if (count_q >= cap_eff) begin
								res_d.status = cqrp_pkg::STAT_FULL;
							end else begin
								mem_we          = 1'b1;
								tail_d          = idx_inc(tail_q, cap_eff);
								count_d         = CNT_W'(count_q + 1'b1);
								res_d.occupancy = count_d;
							end
						end
						cqrp_pkg::KIND_DEQ: begin
							if (count_q == '0) begin
								res_valid        = 1'b1;
								res_d.status     = cqrp_pkg::STAT_EMPTY;
								res_d.read_value = '1;
							end else begin
								head_d  = idx_inc(head_q, cap_eff);
								count_d = CNT_W'(count_q - 1'b1);
							end
						end
						cqrp_pkg::KIND_REV: begin
							if (!rev_ok) begin
								res_valid    = 1'b1;
								res_d.status = cqrp_pkg::STAT_INVALID;
							end else if (rev_pairs == '0) begin
								// A single entry reversed is unchanged.
								res_valid = 1'b1;
							end else begin
								a_d     = head_q;
								b_d     = rev_last;
								pairs_d = rev_pairs;
							end
						end
						default: begin
							res_valid    = 1'b1;
							res_d.status = cqrp_pkg::STAT_INVALID;
						end
					endcase
				end
			end
			cqrp_pkg::ST_DEQ: begin
				res_valid        = 1'b1;
				res_d.read_value = deq_word;
			end
			cqrp_pkg::ST_REV_WA: begin
				// Re-read the current pair so that both read registers keep the
				// words from before this pair's writes.
				mem_we    = 1'b1;
				mem_waddr = a_q;
				mem_wdata = rd_b_q;
				raddr_a   = a_q;
				raddr_b   = b_q;
			end
			cqrp_pkg::ST_REV_WB: begin
				// Finish this pair and fetch the next one in the same cycle;
				// the next pair never includes the slot written here.
				mem_we    = 1'b1;
				mem_waddr = b_q;
				mem_wdata = rd_a_q;
				a_d       = idx_inc(a_q, cap_eff);
				b_d       = idx_dec(b_q, cap_eff);
				pairs_d   = PAIR_W'(pairs_q - 1'b1);
				raddr_a   = a_d;
				raddr_b   = b_d;
				res_valid = (pairs_q == PAIR_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqrp_pkg::ST_IDLE;
			cap_q   <= cqrp_pkg::CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (cfg_we) begin
				// A capacity change empties the queue.
				cap_q   <= cfg_wdata;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q      <= a_d;
		b_q      <= b_d;
		pairs_q  <= pairs_d;
		result_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots_q[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= slots_q[raddr_a];
		rd_b_q <= slots_q[raddr_b];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
